// ===== rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-wire bus master
// request codes, request kinds, status codes, register map, queue items
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 2;

  localparam int unsigned TickW   = 12;
  localparam int unsigned RegW    = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 12;

  localparam logic [RegW-1:0]  WriteOneLowRst  = 10'd9;
  localparam logic [RegW-1:0]  WriteZeroLowRst = 10'd60;
  localparam logic [RegW-1:0]  SlotRst         = 10'd80;
  localparam logic [RegW-1:0]  ReadLowRst      = 10'd9;
  localparam logic [RegW-1:0]  ReadSampleRst   = 10'd9;
  localparam logic [TickW-1:0] ResetLowRst     = 12'd490;
  localparam logic [RegW-1:0]  PresenceWaitRst = 10'd80;
  localparam logic [RegW-1:0]  RecoveryRst     = 10'd240;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_RESET   = 3'd1,
    REQ_WRITE   = 3'd2,
    REQ_READ    = 3'd3,
    REQ_TRIPLET = 3'd4,
    REQ_ARM     = 3'd5,
    REQ_OFF     = 3'd6,
    REQ_RSVD    = 3'd7
  } owm_req_e;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_RESET,
    KIND_WRITE,
    KIND_READ,
    KIND_TRIPLET,
    KIND_ARM,
    KIND_OFF,
    KIND_NOP
  } owm_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NO_PRES   = 3'd3,
    ST_REJ_BUSY  = 3'd4
  } owm_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WRITE_ONE_LOW  = 3'd0,
    CFG_WRITE_ZERO_LOW = 3'd1,
    CFG_SLOT           = 3'd2,
    CFG_READ_LOW       = 3'd3,
    CFG_READ_SAMPLE    = 3'd4,
    CFG_RESET_LOW      = 3'd5,
    CFG_PRESENCE_WAIT  = 3'd6,
    CFG_RECOVERY       = 3'd7
  } owm_cfg_e;

  // classified request, front to back
  typedef struct packed {
    owm_kind_e  kind;
    logic       is_cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       direction_bit;
    logic       bus_level;
  } owm_cmd_t;

  typedef struct packed {
    logic        drive_low;
    logic        strong_pullup;
    logic        busy_res;
    logic        done_res;
    owm_status_e status;
    logic [7:0]  read_data;
    logic [1:0]  triplet_code;
    logic        direction_taken;
  } owm_res_t;

  typedef struct packed {
    logic               we;
    owm_cfg_e           index;
    logic [CfgDatW-1:0] data;
  } owm_cfg_wr_t;

  // read sample point, clamped into [1, slot end]
  function automatic logic [RegW-1:0] sample_point(input logic [RegW-1:0] rl,
                                                   input logic [RegW-1:0] rs,
                                                   input logic [RegW-1:0] slot);
    logic [RegW:0]   sum;
    logic [RegW-1:0] se;
    logic [RegW-1:0] sp;
    sum = {1'b0, rl} + {1'b0, rs};
    se  = (slot == '0) ? RegW'(1) : slot;
    if (sum > {1'b0, se}) begin
      sp = se;
    end else begin
      sp = sum[RegW-1:0];
    end
    if (sp == '0) begin
      sp = RegW'(1);
    end
    return sp;
  endfunction

endpackage

// ===== rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master: timed 1-wire bus master
// requests are classified, queued, then sequenced against microsecond ticks;
// every request gives one result into the result queue
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   push / full               req_type, data_byte, last_byte,
//                                      direction_bit, bus_level
//  result    empty / pop               drive_low, strong_pullup, busy_res,
//                                      done_res, status, read_data,
//                                      triplet_code, direction_taken
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  one request per cycle sustained; the sequencer retires one queued request
//  per cycle and pushes its result into the result queue in the same cycle.
//  the sequencer stalls only when the result queue is full; the request
//  queue then fills and raises full.
//  reset empties both queues, clears the sequencer and loads the timing registers with their reset values.
//  cfg_ready_o is always high; a write takes effect at the next edge.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
  parameter int unsigned CmdDepth = owm_pkg::CmdDepth,
  parameter int unsigned ResDepth = owm_pkg::ResDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      req_type_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  input  logic                            direction_bit_i,
  input  logic                            bus_level_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            drive_low_o,
  output logic                            strong_pullup_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [2:0]                      status_o,
  output logic [7:0]                      read_data_o,
  output logic [1:0]                      triplet_code_o,
  output logic                            direction_taken_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [owm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [owm_pkg::CfgDatW-1:0]     cfg_data_i
);

  owm_pkg::owm_cmd_t    cmd_in, cmd_out;
  owm_pkg::owm_res_t    res_in, res_out;
  owm_pkg::owm_cfg_wr_t cfg_wr;
  logic                 cmd_empty, cmd_pop;
  logic                 res_full, res_push;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.we    = cfg_valid_i;
  assign cfg_wr.index = owm_pkg::owm_cfg_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  owm_front u_front (
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .direction_bit_i (direction_bit_i),
    .bus_level_i     (bus_level_i),
    .cmd_o           (cmd_in)
  );

  owm_fifo #(
    .Depth (CmdDepth),
    .Width ($bits(owm_pkg::owm_cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  owm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  owm_fifo #(
    .Depth (ResDepth),
    .Width ($bits(owm_pkg::owm_res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign drive_low_o       = res_out.drive_low;
  assign strong_pullup_o   = res_out.strong_pullup;
  assign busy_res_o        = res_out.busy_res;
  assign done_res_o        = res_out.done_res;
  assign status_o          = res_out.status;
  assign read_data_o       = res_out.read_data;
  assign triplet_code_o    = res_out.triplet_code;
  assign direction_taken_o = res_out.direction_taken;

endmodule

// ===== rtl/owm_fifo.sv =====
// ----------------------------------------------------------------------------
// owm_fifo: small register queue
// first-word-fall-through queue used between front, back and result port
// ----------------------------------------------------------------------------
module owm_fifo #(
  parameter int unsigned Depth = 2,  // at least two
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/owm_front.sv =====
// ----------------------------------------------------------------------------
// owm_front: request classifier
// decodes the request code into a kind and packs the request for the queue
// ----------------------------------------------------------------------------
module owm_front (
  input  logic            [2:0] req_type_i,
  input  logic            [7:0] data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  direction_bit_i,
  input  logic                  bus_level_i,
  output owm_pkg::owm_cmd_t     cmd_o
);

  owm_pkg::owm_kind_e kind;
  logic               is_cmd;

  always_comb begin
    is_cmd = 1'b1;
    case (owm_pkg::owm_req_e'(req_type_i))
      owm_pkg::REQ_TICK: begin
        kind   = owm_pkg::KIND_TICK;
        is_cmd = 1'b0;
      end
      owm_pkg::REQ_RESET:   kind = owm_pkg::KIND_RESET;
      owm_pkg::REQ_WRITE:   kind = owm_pkg::KIND_WRITE;
      owm_pkg::REQ_READ:    kind = owm_pkg::KIND_READ;
      owm_pkg::REQ_TRIPLET: kind = owm_pkg::KIND_TRIPLET;
      owm_pkg::REQ_ARM:     kind = owm_pkg::KIND_ARM;
      owm_pkg::REQ_OFF:     kind = owm_pkg::KIND_OFF;
      default: begin
        // reserved code: no time passes, nothing starts
        kind   = owm_pkg::KIND_NOP;
        is_cmd = 1'b0;
      end
    endcase
  end

  assign cmd_o.kind          = kind;
  assign cmd_o.is_cmd        = is_cmd;
  assign cmd_o.data_byte     = data_byte_i;
  assign cmd_o.last_byte     = last_byte_i;
  assign cmd_o.direction_bit = direction_bit_i;
  assign cmd_o.bus_level     = bus_level_i;

endmodule

// ===== rtl/owm_back.sv =====
// ----------------------------------------------------------------------------
// owm_back: bus sequencer
// holds the timing registers and runs reset, slot and pullup sequencing,
// one queued request per cycle while the result queue has room, one result per request
// ----------------------------------------------------------------------------
module owm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owm_pkg::owm_cfg_wr_t  cfg_i,
  input  logic                  cmd_valid_i,
  input  owm_pkg::owm_cmd_t     cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output owm_pkg::owm_res_t     res_o
);

  localparam int unsigned TickW = owm_pkg::TickW;
  localparam int unsigned RegW  = owm_pkg::RegW;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_RECOV,
    PH_RST_TAIL,
    PH_WRITE,
    PH_READ,
    PH_TR_READ,
    PH_TR_WRITE
  } phase_e;

  // timing registers
  logic [RegW-1:0]  wr_one_q, wr_zero_q, slot_q, rd_low_q, rd_samp_q;
  logic [TickW-1:0] rst_low_q;
  logic [RegW-1:0]  pres_wait_q, recov_q;
  logic [RegW-1:0]  slot_end_q, samp_pt_q;
  logic [RegW-1:0]  slot_d, rd_low_d, rd_samp_d;

  // sequencer state
  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tc_q, tc_d;
  logic [2:0]       bit_idx_q, bit_idx_d;
  logic [7:0]       shift_q, shift_d;
  logic [1:0]       trip_q, trip_d;
  logic             armed_q, armed_d;
  logic             pull_q, pull_d;
  logic             low_q, low_d;
  logic             pres_q, pres_d;
  logic             final_q, final_d;

  logic             step;
  logic             done;
  owm_pkg::owm_status_e status;
  logic [7:0]       rdata;
  logic [1:0]       tcode;
  logic             dtaken;

  assign step       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;

  // ---------------------------------------------------------------- config
  always_comb begin
    slot_d    = slot_q;
    rd_low_d  = rd_low_q;
    rd_samp_d = rd_samp_q;
    if (cfg_i.we) begin
      case (cfg_i.index)
        owm_pkg::CFG_SLOT:        slot_d    = cfg_i.data[RegW-1:0];
        owm_pkg::CFG_READ_LOW:    rd_low_d  = cfg_i.data[RegW-1:0];
        owm_pkg::CFG_READ_SAMPLE: rd_samp_d = cfg_i.data[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_one_q    <= owm_pkg::WriteOneLowRst;
      wr_zero_q   <= owm_pkg::WriteZeroLowRst;
      slot_q      <= owm_pkg::SlotRst;
      rd_low_q    <= owm_pkg::ReadLowRst;
      rd_samp_q   <= owm_pkg::ReadSampleRst;
      rst_low_q   <= owm_pkg::ResetLowRst;
      pres_wait_q <= owm_pkg::PresenceWaitRst;
      recov_q     <= owm_pkg::RecoveryRst;
      slot_end_q  <= owm_pkg::SlotRst;
      samp_pt_q   <= owm_pkg::sample_point(owm_pkg::ReadLowRst, owm_pkg::ReadSampleRst,
                                           owm_pkg::SlotRst);
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        owm_pkg::CFG_WRITE_ONE_LOW:  wr_one_q    <= cfg_i.data[RegW-1:0];
        owm_pkg::CFG_WRITE_ZERO_LOW: wr_zero_q   <= cfg_i.data[RegW-1:0];
        owm_pkg::CFG_RESET_LOW:      rst_low_q   <= cfg_i.data[TickW-1:0];
        owm_pkg::CFG_PRESENCE_WAIT:  pres_wait_q <= cfg_i.data[RegW-1:0];
        owm_pkg::CFG_RECOVERY:       recov_q     <= cfg_i.data[RegW-1:0];
        default: ;
      endcase
      slot_q     <= slot_d;
      rd_low_q   <= rd_low_d;
      rd_samp_q  <= rd_samp_d;
      // derived slot figures follow the write so the sequencer compares once
      slot_end_q <= (slot_d == '0) ? RegW'(1) : slot_d;
      samp_pt_q  <= owm_pkg::sample_point(rd_low_d, rd_samp_d, slot_d);
    end
  end

  // ------------------------------------------------------------- sequencer
  always_comb begin
    logic [TickW-1:0] tc_inc;
    logic [RegW-1:0]  low_len;
    logic             slot_end;
    logic             was_low;
    logic             sample_now;
    logic [1:0]       trip_new;

    phase_d   = phase_q;
    tc_d      = tc_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    trip_d    = trip_q;
    armed_d   = armed_q;
    pull_d    = pull_q;
    low_d     = low_q;
    pres_d    = pres_q;
    final_d   = final_q;
    done      = 1'b0;
    status    = owm_pkg::ST_OK;
    rdata     = '0;
    tcode     = '0;
    dtaken    = 1'b0;

    tc_inc     = tc_q + TickW'(1);
    was_low    = low_q;
    low_len    = '0;
    slot_end   = 1'b0;
    sample_now = (tc_inc == {{(TickW-RegW){1'b0}}, samp_pt_q}) && cmd_i.bus_level;
    trip_new   = '0;

    if (cmd_i.is_cmd) begin
      if (phase_q != PH_IDLE) begin
        done   = 1'b1;
        status = owm_pkg::ST_REJ_BUSY;
      end else begin
        case (cmd_i.kind)
          owm_pkg::KIND_RESET: begin
            if (!cmd_i.bus_level) begin
              // line already low before the pulse
              done   = 1'b1;
              status = owm_pkg::ST_SHORT;
            end else begin
              pull_d  = 1'b0;
              pres_d  = 1'b0;
              phase_d = PH_RST_LOW;
              tc_d    = '0;
              low_d   = 1'b1;
            end
          end
          owm_pkg::KIND_WRITE: begin
            pull_d    = 1'b0;
            final_d   = cmd_i.last_byte && armed_q;
            if (cmd_i.last_byte) begin
              armed_d = 1'b0;
            end
            shift_d   = cmd_i.data_byte;
            bit_idx_d = '0;
            phase_d   = PH_WRITE;
            tc_d      = '0;
            low_d     = 1'b1;
          end
          owm_pkg::KIND_READ: begin
            pull_d    = 1'b0;
            shift_d   = '0;
            bit_idx_d = '0;
            phase_d   = PH_READ;
            tc_d      = '0;
            low_d     = 1'b1;
          end
          owm_pkg::KIND_TRIPLET: begin
            pull_d    = 1'b0;
            shift_d   = {7'd0, cmd_i.direction_bit};
            trip_d    = '0;
            bit_idx_d = '0;
            phase_d   = PH_TR_READ;
            tc_d      = '0;
            low_d     = 1'b1;
          end
          owm_pkg::KIND_ARM: begin
            armed_d = 1'b1;
            done    = 1'b1;
          end
          default: begin
            // pullup off
            pull_d = 1'b0;
            done   = 1'b1;
          end
        endcase
      end
    end else if (cmd_i.kind == owm_pkg::KIND_TICK) begin
      case (phase_q)
        PH_IDLE: ;
        PH_RST_LOW: begin
          tc_d = tc_inc;
          if (tc_inc >= rst_low_q) begin
            low_d = 1'b0;
            tc_d  = '0;
            if (cmd_i.bus_level) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              status  = owm_pkg::ST_INVALID;
            end else begin
              phase_d = PH_RST_WAIT;
            end
          end
        end
        PH_RST_WAIT: begin
          tc_d = tc_inc;
          if (tc_inc >= {2'b00, pres_wait_q}) begin
            pres_d = !cmd_i.bus_level;
            if (cmd_i.bus_level) begin
              phase_d = PH_RST_TAIL;
              tc_d    = '0;
            end else begin
              // presence sample counts as the first recovery sample
              tc_d = TickW'(1);
              if (recov_q <= RegW'(1)) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
                status  = owm_pkg::ST_SHORT;
              end else begin
                phase_d = PH_RST_RECOV;
              end
            end
          end
        end
        PH_RST_RECOV: begin
          if (cmd_i.bus_level) begin
            phase_d = PH_RST_TAIL;
            tc_d    = '0;
          end else begin
            tc_d = tc_inc;
            if (tc_inc >= {2'b00, recov_q}) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              status  = owm_pkg::ST_SHORT;
            end
          end
        end
        PH_RST_TAIL: begin
          tc_d = tc_inc;
          if (tc_inc >= {2'b00, pres_wait_q}) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            status  = pres_q ? owm_pkg::ST_OK : owm_pkg::ST_NO_PRES;
          end
        end
        PH_WRITE: begin
          low_len  = shift_q[bit_idx_q] ? wr_one_q : wr_zero_q;
          tc_d     = tc_inc;
          slot_end = (tc_inc >= {2'b00, slot_end_q});
          if (tc_inc >= {2'b00, low_len} || slot_end) begin
            low_d = 1'b0;
          end
          // strong pullup takes over as the last bit of a final byte releases
          if (was_low && !low_d && final_q && (bit_idx_q == 3'd7)) begin
            pull_d = 1'b1;
          end
          if (slot_end) begin
            if (bit_idx_q == 3'd7) begin
              phase_d   = PH_IDLE;
              done      = 1'b1;
              final_d   = 1'b0;
              bit_idx_d = '0;
            end else begin
              bit_idx_d = bit_idx_q + 3'd1;
              tc_d      = '0;
              low_d     = 1'b1;
            end
          end
        end
        PH_READ: begin
          tc_d     = tc_inc;
          slot_end = (tc_inc >= {2'b00, slot_end_q});
          if (tc_inc >= {2'b00, rd_low_q} || slot_end) begin
            low_d = 1'b0;
          end
          if (sample_now) begin
            shift_d[bit_idx_q] = 1'b1;
          end
          if (slot_end) begin
            if (bit_idx_q == 3'd7) begin
              phase_d   = PH_IDLE;
              done      = 1'b1;
              bit_idx_d = '0;
              rdata     = shift_d;
            end else begin
              bit_idx_d = bit_idx_q + 3'd1;
              tc_d      = '0;
              low_d     = 1'b1;
            end
          end
        end
        PH_TR_READ: begin
          tc_d     = tc_inc;
          slot_end = (tc_inc >= {2'b00, slot_end_q});
          if (tc_inc >= {2'b00, rd_low_q} || slot_end) begin
            low_d = 1'b0;
          end
          trip_new = trip_q;
          if (sample_now) begin
            trip_new[bit_idx_q[0]] = 1'b1;
          end
          trip_d = trip_new;
          if (slot_end) begin
            if (bit_idx_q == 3'd0) begin
              bit_idx_d = 3'd1;
              tc_d      = '0;
              low_d     = 1'b1;
            end else begin
              bit_idx_d = '0;
              if (trip_new == 2'b11) begin
                shift_d = '0;
                phase_d = PH_IDLE;
                done    = 1'b1;
                tcode   = 2'b11;
              end else begin
                // one bit read as one forces its own direction
                if (trip_new != 2'b00) begin
                  shift_d = {7'd0, (trip_new == 2'b01)};
                end else begin
                  shift_d = {7'd0, shift_q[0]};
                end
                phase_d = PH_TR_WRITE;
                tc_d    = '0;
                low_d   = 1'b1;
              end
            end
          end
        end
        PH_TR_WRITE: begin
          low_len  = shift_q[0] ? wr_one_q : wr_zero_q;
          tc_d     = tc_inc;
          slot_end = (tc_inc >= {2'b00, slot_end_q});
          if (tc_inc >= {2'b00, low_len} || slot_end) begin
            low_d = 1'b0;
          end
          if (slot_end) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            tcode   = trip_q;
            dtaken  = shift_q[0];
          end
        end
        default: begin
          phase_d = PH_IDLE;
          low_d   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tc_q      <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      trip_q    <= '0;
      armed_q   <= 1'b0;
      pull_q    <= 1'b0;
      low_q     <= 1'b0;
      pres_q    <= 1'b0;
      final_q   <= 1'b0;
    end else if (step) begin
      phase_q   <= phase_d;
      tc_q      <= tc_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      trip_q    <= trip_d;
      armed_q   <= armed_d;
      pull_q    <= pull_d;
      low_q     <= low_d;
      pres_q    <= pres_d;
      final_q   <= final_d;
    end
  end

  assign res_o.drive_low       = low_d;
  assign res_o.strong_pullup   = pull_d;
  assign res_o.busy_res        = (phase_d != PH_IDLE);
  assign res_o.done_res        = done;
  assign res_o.status          = status;
  assign res_o.read_data       = rdata;
  assign res_o.triplet_code    = tcode;
  assign res_o.direction_taken = dtaken;

`ifndef SYNTHESIS
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> !low_q)
    else $error("line driven low while idle");

  a_pullup_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pull_q |-> !low_q)
    else $error("strong pullup on while line driven low");

  a_triplet_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TR_READ || phase_q == PH_TR_WRITE) |-> (bit_idx_q <= 3'd1))
    else $error("triplet bit index out of range");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_o.done_res && res_o.status == owm_pkg::ST_REJ_BUSY) |-> res_o.busy_res)
    else $error("rejected request left the sequencer idle");

  a_data_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (res_o.read_data != '0 || res_o.triplet_code != '0)) |-> res_o.done_res)
    else $error("read data reported without completion");

  a_no_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(phase_q) && $stable(tc_q))
    else $error("sequencer moved without a request");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 1-wire bus master
// requests are queued by a stimulus block and pushed by a clocked driver;
// every accepted request is run through a cycle-free model of the sequencer
// and the result it gives is compared field by field with what the block pops
// ----------------------------------------------------------------------------
module testbench;
  import owm_pkg::*;

  localparam int StallLimit = 5000;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RST_LOW,
    SEQ_RST_WAIT,
    SEQ_RST_RECOV,
    SEQ_RST_TAIL,
    SEQ_WRITE,
    SEQ_READ,
    SEQ_TR_READ,
    SEQ_TR_WRITE
  } seq_e;

  typedef struct packed {
    logic [9:0]  wr_one_low, wr_zero_low, slot_len, rd_low, rd_sample;
    logic [11:0] rst_low;
    logic [9:0]  pres_wait, recov_limit;
    seq_e        seq;
    logic [11:0] ticks;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic [1:0]  tbits;
    logic        armed, spu_on, low, presence, final_wr;
  } bus_state_t;

  typedef struct packed {
    owm_req_e   req;
    logic [7:0] data;
    logic       last;
    logic       dir;
    logic       level;
    logic       hold;
  } bus_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] req_type_i = '0;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       direction_bit_i = 1'b0;
  logic       bus_level_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       drive_low_o, strong_pullup_o, busy_res_o, done_res_o;
  logic [2:0] status_o;
  logic [7:0] read_data_o;
  logic [1:0] triplet_code_o;
  logic       direction_taken_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;

  bus_req_t   req_q[$];
  owm_res_t   bus_res_q[$];
  bus_state_t seen_bus;
  bus_state_t plan_bus;
  bit         req_taken = 1'b0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         resets_left = 0;
  int         reqs_made = 0;
  int         stall_cycles = 0;
  int         mismatches = 0;

  one_wire_bus_master dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .direction_bit_i  (direction_bit_i),
    .bus_level_i      (bus_level_i),
    .empty            (empty),
    .pop              (pop),
    .drive_low_o      (drive_low_o),
    .strong_pullup_o  (strong_pullup_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .read_data_o      (read_data_o),
    .triplet_code_o   (triplet_code_o),
    .direction_taken_o(direction_taken_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic bus_state_t idle_bus();
    bus_state_t s;
    s = '0;
    s.wr_one_low  = WriteOneLowRst;
    s.wr_zero_low = WriteZeroLowRst;
    s.slot_len    = SlotRst;
    s.rd_low      = ReadLowRst;
    s.rd_sample   = ReadSampleRst;
    s.rst_low     = ResetLowRst;
    s.pres_wait   = PresenceWaitRst;
    s.recov_limit = RecoveryRst;
    s.seq         = SEQ_IDLE;
    return s;
  endfunction

  function automatic void set_timing(inout bus_state_t s, input owm_cfg_e idx,
                                     input logic [11:0] v);
    case (idx)
      CFG_WRITE_ONE_LOW:  s.wr_one_low  = v[9:0];
      CFG_WRITE_ZERO_LOW: s.wr_zero_low = v[9:0];
      CFG_SLOT:           s.slot_len    = v[9:0];
      CFG_READ_LOW:       s.rd_low      = v[9:0];
      CFG_READ_SAMPLE:    s.rd_sample   = v[9:0];
      CFG_RESET_LOW:      s.rst_low     = v;
      CFG_PRESENCE_WAIT:  s.pres_wait   = v[9:0];
      default:            s.recov_limit = v[9:0];
    endcase
  endfunction

  // one tick of a time slot, true on the tick that closes it
  function automatic logic slot_tick(inout bus_state_t s, input logic [9:0] low_len);
    logic [11:0] slot_end;
    slot_end = (s.slot_len == '0) ? 12'd1 : {2'b00, s.slot_len};
    s.ticks = s.ticks + 12'd1;
    if (s.ticks >= {2'b00, low_len}) s.low = 1'b0;
    if (s.ticks >= slot_end) begin
      s.low = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [11:0] sample_at(input bus_state_t s);
    int unsigned sp;
    int unsigned slot_end;
    slot_end = (s.slot_len == '0) ? 1 : s.slot_len;
    sp = s.rd_low + s.rd_sample;
    if (sp > slot_end) sp = slot_end;
    if (sp < 1) sp = 1;
    return 12'(sp);
  endfunction

  function automatic void begin_slot(inout bus_state_t s);
    s.ticks = '0;
    s.low   = 1'b1;
  endfunction

  function automatic owm_res_t master_step(inout bus_state_t s, input bus_req_t r);
    owm_res_t res;
    logic     was_low;
    logic     fin;
    res = '0;
    res.status = ST_OK;
    if (r.req == REQ_TICK) begin
      was_low = s.low;
      case (s.seq)
        SEQ_RST_LOW: begin
          s.ticks = s.ticks + 12'd1;
          if (s.ticks >= s.rst_low) begin
            s.low = 1'b0;
            s.ticks = '0;
            if (r.level) begin
              s.seq = SEQ_IDLE;
              res.done_res = 1'b1;
              res.status = ST_INVALID;
            end else begin
              s.seq = SEQ_RST_WAIT;
            end
          end
        end
        SEQ_RST_WAIT: begin
          s.ticks = s.ticks + 12'd1;
          if (s.ticks >= {2'b00, s.pres_wait}) begin
            s.presence = !r.level;
            if (r.level) begin
              s.seq = SEQ_RST_TAIL;
              s.ticks = '0;
            end else begin
              // presence sample is the first recovery sample
              s.ticks = 12'd1;
              if (s.recov_limit <= 10'd1) begin
                s.seq = SEQ_IDLE;
                res.done_res = 1'b1;
                res.status = ST_SHORT;
              end else begin
                s.seq = SEQ_RST_RECOV;
              end
            end
          end
        end
        SEQ_RST_RECOV: begin
          if (r.level) begin
            s.seq = SEQ_RST_TAIL;
            s.ticks = '0;
          end else begin
            s.ticks = s.ticks + 12'd1;
            if (s.ticks >= {2'b00, s.recov_limit}) begin
              s.seq = SEQ_IDLE;
              res.done_res = 1'b1;
              res.status = ST_SHORT;
            end
          end
        end
        SEQ_RST_TAIL: begin
          s.ticks = s.ticks + 12'd1;
          if (s.ticks >= {2'b00, s.pres_wait}) begin
            s.seq = SEQ_IDLE;
            res.done_res = 1'b1;
            res.status = s.presence ? ST_OK : ST_NO_PRES;
          end
        end
        SEQ_WRITE: begin
          fin = slot_tick(s, s.shreg[s.bit_idx] ? s.wr_one_low : s.wr_zero_low);
          // strong pullup comes on at the release in the last bit
          if (was_low && !s.low && s.final_wr && s.bit_idx == 3'd7) s.spu_on = 1'b1;
          if (fin) begin
            if (s.bit_idx == 3'd7) begin
              s.seq = SEQ_IDLE;
              res.done_res = 1'b1;
              s.final_wr = 1'b0;
              s.bit_idx = '0;
            end else begin
              s.bit_idx = s.bit_idx + 3'd1;
              begin_slot(s);
            end
          end
        end
        SEQ_READ: begin
          fin = slot_tick(s, s.rd_low);
          if (s.ticks == sample_at(s) && r.level) s.shreg[s.bit_idx] = 1'b1;
          if (fin) begin
            if (s.bit_idx == 3'd7) begin
              s.seq = SEQ_IDLE;
              res.done_res = 1'b1;
              s.bit_idx = '0;
              res.read_data = s.shreg;
            end else begin
              s.bit_idx = s.bit_idx + 3'd1;
              begin_slot(s);
            end
          end
        end
        SEQ_TR_READ: begin
          fin = slot_tick(s, s.rd_low);
          if (s.ticks == sample_at(s) && r.level) s.tbits[s.bit_idx[0]] = 1'b1;
          if (fin) begin
            if (s.bit_idx == 3'd0) begin
              s.bit_idx = 3'd1;
              begin_slot(s);
            end else begin
              s.bit_idx = '0;
              if (s.tbits == 2'd3) begin
                // no device answered either way: nothing is written
                s.shreg = '0;
                s.seq = SEQ_IDLE;
                res.done_res = 1'b1;
                res.triplet_code = 2'd3;
              end else begin
                if (s.tbits != 2'd0) s.shreg = (s.tbits == 2'd1) ? 8'd1 : 8'd0;
                else s.shreg = s.shreg & 8'd1;
                s.seq = SEQ_TR_WRITE;
                begin_slot(s);
              end
            end
          end
        end
        SEQ_TR_WRITE: begin
          fin = slot_tick(s, s.shreg[0] ? s.wr_one_low : s.wr_zero_low);
          if (fin) begin
            s.seq = SEQ_IDLE;
            res.done_res = 1'b1;
            res.triplet_code = s.tbits;
            res.direction_taken = s.shreg[0];
          end
        end
        default: begin
          s.seq = SEQ_IDLE;
          s.low = 1'b0;
        end
      endcase
    end else if (r.req != REQ_RSVD) begin
      if (s.seq != SEQ_IDLE) begin
        res.done_res = 1'b1;
        res.status = ST_REJ_BUSY;
      end else begin
        case (r.req)
          REQ_RESET: begin
            if (!r.level) begin
              res.done_res = 1'b1;
              res.status = ST_SHORT;
            end else begin
              s.spu_on = 1'b0;
              s.presence = 1'b0;
              s.seq = SEQ_RST_LOW;
              s.ticks = '0;
              s.low = 1'b1;
            end
          end
          REQ_WRITE: begin
            s.spu_on = 1'b0;
            s.final_wr = r.last && s.armed;
            if (r.last) s.armed = 1'b0;
            s.shreg = r.data;
            s.bit_idx = '0;
            s.seq = SEQ_WRITE;
            begin_slot(s);
          end
          REQ_READ: begin
            s.spu_on = 1'b0;
            s.shreg = '0;
            s.bit_idx = '0;
            s.seq = SEQ_READ;
            begin_slot(s);
          end
          REQ_TRIPLET: begin
            s.spu_on = 1'b0;
            s.shreg = {7'd0, r.dir};
            s.tbits = '0;
            s.bit_idx = '0;
            s.seq = SEQ_TR_READ;
            begin_slot(s);
          end
          REQ_ARM: begin
            s.armed = 1'b1;
            res.done_res = 1'b1;
          end
          default: begin
            s.spu_on = 1'b0;
            res.done_res = 1'b1;
          end
        endcase
      end
    end
    res.drive_low = s.low;
    res.strong_pullup = s.spu_on;
    res.busy_res = (s.seq != SEQ_IDLE);
    return res;
  endfunction

  // ------------------------------------------------------- driver, monitor

  always @(negedge clk_i) begin
    if (!(push && !req_taken)) begin
      if (rst_ni && req_q.size() != 0 && !(req_q[0].hold && bus_res_q.size() != 0)
          && $urandom_range(99) >= send_idle) begin
        push            <= 1'b1;
        req_type_i      <= req_q[0].req;
        data_byte_i     <= req_q[0].data;
        last_byte_i     <= req_q[0].last;
        direction_bit_i <= req_q[0].dir;
        bus_level_i     <= req_q[0].level;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : watch
    owm_res_t want;
    bus_req_t taken;
    bit       moved;
    moved = 1'b0;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        moved = 1'b1;
        if (bus_res_q.size() == 0) begin
          flag_mismatch("result popped with nothing awaited");
        end else begin
          want = bus_res_q.pop_front();
          check_field("drive_low", 8'(drive_low_o), 8'(want.drive_low));
          check_field("strong_pullup", 8'(strong_pullup_o), 8'(want.strong_pullup));
          check_field("busy_res", 8'(busy_res_o), 8'(want.busy_res));
          check_field("done_res", 8'(done_res_o), 8'(want.done_res));
          check_field("status", 8'(status_o), 8'(want.status));
          check_field("read_data", read_data_o, want.read_data);
          check_field("triplet_code", 8'(triplet_code_o), 8'(want.triplet_code));
          check_field("direction_taken", 8'(direction_taken_o),
                      8'(want.direction_taken));
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        req_taken = 1'b1;
        taken = req_q.pop_front();
        want = master_step(seen_bus, taken);
        bus_res_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        set_timing(seen_bus, owm_cfg_e'(cfg_index_i), cfg_data_i);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- stimulus

  function automatic bus_req_t make_req(input owm_req_e kind, input logic [7:0] d,
                                        input logic last, input logic dir,
                                        input logic level);
    bus_req_t r;
    r.req = kind;
    r.data = d;
    r.last = last;
    r.dir = dir;
    r.level = level;
    r.hold = 1'b0;
    return r;
  endfunction

  function automatic bus_req_t rand_req(input owm_req_e kind);
    return make_req(kind, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // line level shaped so that resets mostly see a proper presence pulse
  function automatic logic line_for(input bus_state_t s, input bit stuck);
    int nxt;
    nxt = s.ticks + 1;
    case (s.seq)
      SEQ_RST_LOW:   return (nxt >= s.rst_low) ? ($urandom_range(7) == 0)
                                               : 1'($urandom_range(1));
      SEQ_RST_WAIT:  return (nxt >= s.pres_wait) ? ($urandom_range(3) == 0)
                                                 : 1'($urandom_range(1));
      SEQ_RST_RECOV: return stuck ? 1'b0 : ($urandom_range(2) == 0);
      default:       return 1'($urandom_range(1));
    endcase
  endfunction

  task automatic add_item(input bus_req_t r);
    req_q.push_back(r);
    void'(master_step(plan_bus, r));
    if (r.req != REQ_RSVD) reqs_made++;
  endtask

  task automatic make_transaction();
    bus_req_t r;
    int       pick;
    int       noise;
    bit       stuck;
    pick = $urandom_range(99);
    stuck = ($urandom_range(4) == 0);
    if (pick < 22 && resets_left > 0) begin
      r = rand_req(REQ_RESET);
      r.level = ($urandom_range(9) != 0);
      resets_left--;
    end else if (pick < 44) begin
      if ($urandom_range(2) == 0) add_item(rand_req(REQ_ARM));
      r = rand_req(REQ_WRITE);
    end else if (pick < 62) begin
      r = rand_req(REQ_READ);
    end else if (pick < 80) begin
      r = rand_req(REQ_TRIPLET);
    end else if (pick < 88) begin
      r = rand_req(REQ_ARM);
    end else if (pick < 94) begin
      r = rand_req(REQ_OFF);
    end else if (pick < 97) begin
      r = rand_req(REQ_RSVD);
    end else begin
      r = rand_req(REQ_TICK);
    end
    r.hold = ($urandom_range(59) == 0);
    add_item(r);
    while (plan_bus.seq != SEQ_IDLE) begin
      noise = $urandom_range(79);
      if (noise == 0) r = rand_req(owm_req_e'($urandom_range(6, 1)));
      else if (noise == 1) r = rand_req(REQ_RSVD);
      else begin
        r = rand_req(REQ_TICK);
        r.level = line_for(plan_bus, stuck);
      end
      add_item(r);
    end
    repeat ($urandom_range(2)) add_item(rand_req(REQ_TICK));
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || bus_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input owm_cfg_e idx, input logic [11:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    set_timing(plan_bus, idx, v);
  endtask

  task automatic program_timing(input logic [11:0] wo, input logic [11:0] wz,
                                input logic [11:0] slot, input logic [11:0] rl,
                                input logic [11:0] rs, input logic [11:0] rst,
                                input logic [11:0] pw, input logic [11:0] rec);
    wait_drained();
    write_reg(CFG_WRITE_ONE_LOW, wo);
    write_reg(CFG_WRITE_ZERO_LOW, wz);
    write_reg(CFG_SLOT, slot);
    write_reg(CFG_READ_LOW, rl);
    write_reg(CFG_READ_SAMPLE, rs);
    write_reg(CFG_RESET_LOW, rst);
    write_reg(CFG_PRESENCE_WAIT, pw);
    write_reg(CFG_RECOVERY, rec);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // small timing value with junk in the bits above the register
  function automatic logic [11:0] rnd_reg(input int lo, input int hi);
    return {2'($urandom_range(3)), 10'($urandom_range(hi, lo))};
  endfunction

  task automatic run_random(input int n, input int s_idle, input int r_idle,
                            input int resets);
    int start;
    send_idle = s_idle;
    recv_idle = r_idle;
    resets_left = resets;
    start = reqs_made;
    while (reqs_made - start < n) make_transaction();
  endtask

  initial begin
    bus_req_t r;
    seen_bus = idle_bus();
    plan_bus = idle_bus();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle = 29;
    recv_idle = 76;
    program_timing(12'd1, 12'd3, 12'd4, 12'd1, 12'd1, 12'd3, 12'd2, 12'd3);
    add_item(make_req(REQ_RSVD, 8'hFF, 1'b1, 1'b1, 1'b1));
    add_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    add_item(make_req(REQ_RESET, 8'h00, 1'b0, 1'b0, 1'b0));   // line already low
    add_item(make_req(REQ_ARM, 8'hA5, 1'b0, 1'b1, 1'b1));
    add_item(make_req(REQ_OFF, 8'h5A, 1'b1, 1'b0, 1'b1));
    add_item(make_req(REQ_RESET, 8'hFF, 1'b1, 1'b1, 1'b1));
    add_item(make_req(REQ_RESET, 8'h00, 1'b0, 1'b0, 1'b1));   // refused while busy
    add_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    add_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    add_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b1));    // high at pulse end
    r = make_req(REQ_RESET, 8'h00, 1'b0, 1'b0, 1'b1);
    r.hold = 1'b1;
    add_item(r);
    repeat (3) add_item(make_req(REQ_TICK, 8'hFF, 1'b1, 1'b1, 1'b0));
    repeat (4) add_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b1));  // nobody answers
    add_item(make_req(REQ_ARM, 8'h00, 1'b0, 1'b0, 1'b1));
    add_item(make_req(REQ_WRITE, 8'h00, 1'b1, 1'b0, 1'b1));
    add_item(make_req(REQ_READ, 8'hFF, 1'b1, 1'b1, 1'b1));
    add_item(make_req(REQ_TRIPLET, 8'h00, 1'b0, 1'b1, 1'b0));
    add_item(make_req(REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1));
    add_item(make_req(REQ_OFF, 8'h00, 1'b0, 1'b0, 1'b0));
    add_item(make_req(REQ_ARM, 8'hFF, 1'b1, 1'b1, 1'b1));
    run_random(140, 29, 76, 1000);

    // zero slot, zero reset and wait lengths, low times past the slot end
    program_timing(12'hFFF, 12'hFFF, 12'hC00, 12'hFFF, 12'hFFF, 12'h000, 12'h400, 12'h801);
    run_random(140, 29, 76, 1000);

    program_timing(rnd_reg(1, 12), rnd_reg(1, 12), rnd_reg(2, 12), rnd_reg(1, 12),
                   rnd_reg(1, 12), 12'($urandom_range(24, 1)), rnd_reg(1, 12),
                   rnd_reg(1, 12));
    run_random(140, 76, 29, 1000);

    program_timing(12'd1, 12'd2, 12'd2, 12'd2, 12'd1, 12'd1, 12'd1, 12'd2);
    run_random(140, 76, 29, 1000);

    // reset pulse longer than ten bits can count, one reset up front
    program_timing(12'd1023, 12'd12, 12'd12, 12'd5, 12'd1023, 12'd1030, 12'd30,
                   12'd30);
    add_item(make_req(REQ_RESET, 8'h00, 1'b0, 1'b0, 1'b1));
    while (plan_bus.seq != SEQ_IDLE) begin
      add_item(make_req(REQ_TICK, 8'h00, 1'b0, 1'b0, line_for(plan_bus, 1'b0)));
    end
    run_random(100, 0, 0, 0);

    program_timing(rnd_reg(1, 16), rnd_reg(1, 16), rnd_reg(2, 16), rnd_reg(1, 16),
                   rnd_reg(1, 16), 12'($urandom_range(40, 1)), rnd_reg(1, 16),
                   rnd_reg(1, 16));
    run_random(100, 0, 0, 1000);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
